### src/crc32re_pkg.sv
// ----------------------------------------------------------------------------
// crc32re_pkg
// Shared constants, queue entry type and the byte-absorb function for the
// reflected CRC-32 / CRC-32C engine.
// ----------------------------------------------------------------------------
package crc32re_pkg;

   localparam int BYTES_PER_ITEM = 8;
   localparam int DATA_W         = 64;
   localparam int CNT_W          = 4;
   localparam int SEED_W         = 32;
   localparam int CRC_W          = 32;

   // req tdata: data_bytes, byte_count, seed, padded to whole bytes
   localparam int REQ_RAW_W      = DATA_W + CNT_W + SEED_W;
   localparam int REQ_TDATA_W    = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W    = CRC_W;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CRC_W-1:0] POLY_CRC32  = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] POLY_CRC32C = 32'h82F6_3B78;

   typedef enum logic {
      KIND_CRC32  = 1'b0,
      KIND_CRC32C = 1'b1
   } crc_kind_type;

   // one classified item waiting for the back end
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  cnt;    // already saturated to BYTES_PER_ITEM
      logic              first;
      logic [SEED_W-1:0] seed;
      logic              last;
   } item_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // absorb one byte, LSB first, reflected polynomial
   function automatic logic [CRC_W-1:0] crc_absorb_byte(
      input logic [CRC_W-1:0] crc_i,
      input logic [7:0]       byte_i,
      input crc_kind_type     kind_i
   );
      logic [CRC_W-1:0] c;
      logic [CRC_W-1:0] poly;
      poly = (kind_i == KIND_CRC32C) ? POLY_CRC32C : POLY_CRC32;
      c = crc_i ^ {{(CRC_W-8){1'b0}}, byte_i};
      for (int b = 0; b < 8; b++) begin
         c = (c >> 1) ^ (c[0] ? poly : '0);
      end
      return c;
   endfunction

endpackage

### src/crc32re_front.sv
// ----------------------------------------------------------------------------
// crc32re_front
// Accepts request items, unpacks them and clamps the byte count.
// ----------------------------------------------------------------------------
module crc32re_front
   import crc32re_pkg::*;
(
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   input  q_stat_type             q_stat,
   output logic                   push,
   output item_type               push_item
);

   logic [CNT_W-1:0] cnt_raw;

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;
   assign cnt_raw    = req_tdata[DATA_W +: CNT_W];

   always_comb begin
      push_item.data  = req_tdata[DATA_W-1:0];
      push_item.seed  = req_tdata[DATA_W+CNT_W +: SEED_W];
      push_item.first = req_tuser;
      push_item.last  = req_tlast;
      // counts above the lane count saturate
      if (cnt_raw > CNT_W'(BYTES_PER_ITEM)) begin
         push_item.cnt = CNT_W'(BYTES_PER_ITEM);
      end else begin
         push_item.cnt = cnt_raw;
      end
   end

endmodule

### src/crc32re_queue.sv
// ----------------------------------------------------------------------------
// crc32re_queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
module crc32re_queue
   import crc32re_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  item_type   push_item,
   input  logic       pop,
   output item_type   head_item,
   output q_stat_type q_stat
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign head_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/crc32re_back.sv
// ----------------------------------------------------------------------------
// crc32re_back
// Folds the queued bytes into the running CRC and holds the result register.
// ----------------------------------------------------------------------------
module crc32re_back
   import crc32re_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  item_type               head_item,
   input  q_stat_type             q_stat,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   crc_kind_type           kind_ff, kind_in;
   logic [CRC_W-1:0]       run_crc_ff, run_crc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0]       rsp_crc_ff;
   logic                   rsp_last_ff;
   logic [CRC_W-1:0]       stage [0:BYTES_PER_ITEM];

   assign pop = !q_stat.empty && (!rsp_valid_ff || rsp_tready);

   // byte chain; result tapped after cnt bytes
   always_comb begin
      stage[0] = head_item.first ? head_item.seed : run_crc_ff;
      for (int i = 0; i < BYTES_PER_ITEM; i++) begin
         stage[i+1] = crc_absorb_byte(stage[i], head_item.data[8*i +: 8], kind_ff);
      end
   end

   always_comb begin
      kind_in      = csr_wr_en ? crc_kind_type'(csr_wr_data) : kind_ff;
      run_crc_in   = pop ? stage[head_item.cnt] : run_crc_ff;
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_CRC32;
         run_crc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         run_crc_ff   <= run_crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_crc_ff  <= stage[head_item.cnt];
         rsp_last_ff <= head_item.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_crc_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### src/crc32_reflected_engine_core.sv
// ----------------------------------------------------------------------------
// crc32_reflected_engine_core
// Streaming reflected CRC-32 / CRC-32C engine, up to eight bytes per item.
// ----------------------------------------------------------------------------
// Each request item carries up to eight message bytes (earliest byte in the
// low byte lane) and a valid byte count; counts above eight are treated as
// eight, a count of zero absorbs nothing. With tuser set the item starts a
// message and its seed replaces the running CRC first. Every item gives one
// response item with the updated CRC (no final inversion) and tlast echoed.
// Throughput is one item per clock while responses are taken: the eight-byte
// fold against the running CRC is one combinational XOR network, whose
// feedback path sets the clock limit. A request is registered in the queue,
// then in the response register. A two-item queue between front and back end
// means a stalled response only blocks requests once the queue is full.
// csr_wr_data selects the polynomial (0 = CRC-32, 1 = CRC-32C); write it only
// while the engine is idle.
// ----------------------------------------------------------------------------
module crc32_reflected_engine_core
   import crc32re_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // data_bytes[63:0], byte_count[67:64],
                                              // seed[99:68], zero pad above
   input  logic                   req_tuser,  // first
   input  logic                   req_tlast,  // last
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // crc_value[31:0]
   output logic                   rsp_tlast,  // final_res
   // configuration
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data // crc_kind
);

   q_stat_type q_stat;
   logic       push;
   logic       pop;
   item_type   push_item;
   item_type   head_item;

   // front end: handshake, unpack, clamp count
   crc32re_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   // decoupling queue
   crc32re_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   // back end: running CRC, mode register, response register
   crc32re_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_item   (head_item),
      .q_stat      (q_stat),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### src/crc32re_checker.sv
// ----------------------------------------------------------------------------
// crc32re_checker
// Port-level checks on the CRC engine, bound to the top level.
// ----------------------------------------------------------------------------
module crc32re_checker
   import crc32re_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // reset empties the response register
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // queue comes out of reset empty, so requests are taken at once
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready)
      else $error("request not ready after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // a response only leaves by handshake
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid) |-> $past(rsp_tready))
      else $error("response dropped without handshake");

endmodule

bind crc32_reflected_engine_core crc32re_checker u_crc32re_checker (.*);

### tb/tb_crc32_reflected_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc32_reflected_engine_core
// Self-checking bench for the streaming reflected CRC-32 / CRC-32C engine.
// ----------------------------------------------------------------------------
// A bit-serial CRC model runs next to the engine. Each request item accepted
// on the slave side is folded into the model's running CRC, and the result is
// queued. Every response item is checked against the oldest queued result.
// Directed items cover known check values, zero and oversize byte counts,
// junk above the count, seed extremes and a polynomial change mid-message.
// Random messages follow with both polynomials, random gaps and stalls, a
// long response hold-off and a stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_crc32_reflected_engine_core;
   import crc32re_pkg::*;

   localparam logic [31:0] ETH_POLY        = 32'hEDB8_8320;
   localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          MAX_REPORTS     = 10;

   typedef struct packed {
      logic [31:0] crc;
      logic        fin;
   } crc_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wr_en;
   logic                   csr_wr_data;

   // model state
   crc_kind_type   kind_model;
   logic [31:0]    crc_model;
   crc_result_type crc_expect_q[$];

   // stimulus controls
   int unsigned   req_idle_pct;
   int unsigned   rsp_idle_pct;
   int            rsp_hold_left;

   // run statistics
   int            cycle_count;
   int            mismatches;
   int            items_sent;
   int            items_crc32;
   int            items_crc32c;
   int            msgs_started;
   int            rsp_checked;
   int            kind_writes;

   crc32_reflected_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // bit-serial reflected CRC: each data bit enters at bit 0, LSB first
   // ---------------------------------------------------------------------
   function automatic logic [31:0] fold_bytes(input logic [31:0]  crc_in,
                                              input logic [63:0]  data,
                                              input logic [3:0]   cnt,
                                              input crc_kind_type kind);
      logic [31:0] c;
      logic [31:0] poly;
      int          nbits;
      poly  = (kind == KIND_CRC32C) ? CASTAGNOLI_POLY : ETH_POLY;
      nbits = ((cnt > 4'd8) ? 8 : int'(cnt)) * 8;
      c     = crc_in;
      for (int k = 0; k < 64; k++) begin
         if (k < nbits)
            c = (c >> 1) ^ ((c[0] ^ data[k]) ? poly : 32'h0);
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] mismatch, %s: expected %08h, got %08h", $time, what, exp_v, act_v);
   endtask

   // ---------------------------------------------------------------------
   // drive one request item, wait for the handshake, predict its response
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [63:0] d, input logic [3:0] n, input logic f,
                            input logic [31:0] s, input logic l);
      logic [31:0] start_crc;
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_TDATA_W - 100){1'b0}}, s, n, d};
      req_tuser  = f;
      req_tlast  = l;
      do @(posedge clock); while (!req_tready);
      start_crc = f ? s : crc_model;
      crc_model = fold_bytes(start_crc, d, n, kind_model);
      crc_expect_q.push_back('{crc: crc_model, fin: l});
      items_sent++;
      if (f)
         msgs_started++;
      if (kind_model == KIND_CRC32C)
         items_crc32c++;
      else
         items_crc32++;
   endtask

   // stop offering and let every pending response come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (crc_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_kind(input crc_kind_type k);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = k;
      @(posedge clock);
      kind_model = k;
      kind_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // no config write yet: running CRC of zero and CRC-32 after reset
   task automatic test_reset_state();
      send_item(64'h0123_4567_89AB_CDEF, 4'd4, 1'b0, 32'hFFFF_FFFF, 1'b0);
      wait_idle();
   endtask

   task automatic test_directed_vectors();
      // standard check string, split into a full and a one-byte item
      send_item(64'h3837_3635_3433_3231, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_item(64'hA5A5_A5A5_A5A5_A539, 4'd1, 1'b0, 32'h0, 1'b1);
      if (crc_model != 32'h340B_C6D9)
         report_mismatch("model CRC-32 check value", 32'h340B_C6D9, crc_model);
      // zero count with a seed load, then zero count continuing
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 32'hDEAD_BEEF, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 32'h1234_5678, 1'b0);
      // continuing after last without a new first
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 32'h0, 1'b1);
      // counts above eight saturate
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1, 32'h0, 1'b0);
      send_item(64'h0, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_item(64'h5A5A_5A5A_5A5A_5A5A, 4'd12, 1'b0, 32'hFFFF_FFFF, 1'b1);
      // every count from one to eight with junk above it
      for (int i = 1; i <= 8; i++)
         send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'(i), (i == 1), 32'hFFFF_FFFF, (i == 8));
      wait_idle();

      write_kind(KIND_CRC32C);
      send_item(64'h3837_3635_3433_3231, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_item(64'h0000_0000_0000_0039, 4'd1, 1'b0, 32'h0, 1'b1);
      if (crc_model != 32'h1CF9_6D7C)
         report_mismatch("model CRC-32C check value", 32'h1CF9_6D7C, crc_model);
      send_item(64'h0, 4'd0, 1'b1, 32'h0, 1'b0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 32'hFFFF_FFFF, 1'b0);
      send_item(64'h8000_0000_0000_0001, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b1);
      wait_idle();
   endtask

   // polynomial changed between items of one message, engine idle each time
   task automatic test_kind_switch();
      send_item(64'h0F1E_2D3C_4B5A_6978, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b0);
      wait_idle();
      write_kind(KIND_CRC32);
      send_item(64'h8796_A5B4_C3D2_E1F0, 4'd8, 1'b0, 32'h0, 1'b0);
      send_item(64'h1122_3344_5566_7788, 4'd5, 1'b0, 32'h0, 1'b0);
      wait_idle();
      write_kind(KIND_CRC32C);
      write_kind(KIND_CRC32C);
      send_item(64'h99AA_BBCC_DDEE_FF00, 4'd3, 1'b0, 32'h0, 1'b1);
      wait_idle();
   endtask

   // hold responses off long enough that the queue fills and requests stall
   task automatic test_backpressure();
      req_idle_pct  = 0;
      rsp_hold_left = 120;
      for (int i = 0; i < 24; i++)
         send_item({$urandom, $urandom}, 4'($urandom_range(1, 8)), (i == 0),
                   32'hFFFF_FFFF, (i == 23));
      wait_idle();
      req_idle_pct = 27;
   endtask

   // mostly well-formed messages, with some noise items mixed in
   task automatic test_random_messages(input int n_items, input int unsigned idle_pct);
      int          sent;
      int          len;
      int unsigned roll;
      logic [3:0]  n;
      logic        f;
      logic        l;
      logic [31:0] s;
      sent         = 0;
      req_idle_pct = idle_pct;
      rsp_idle_pct = idle_pct;
      while (sent < n_items) begin
         len  = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         roll = $urandom_range(9);
         s    = (roll < 5) ? 32'hFFFF_FFFF : (roll == 5) ? 32'h0 : 32'($urandom);
         for (int i = 0; i < len; i++) begin
            f = (i == 0);
            l = (i == len - 1);
            if (l || $urandom_range(3) == 0)
               n = 4'($urandom_range(1, 8));
            else
               n = 4'd8;
            if ($urandom_range(99) < 12) begin
               f = 1'($urandom);
               l = 1'($urandom);
               n = 4'($urandom_range(15));
            end
            send_item({$urandom, $urandom}, n, f, f ? s : 32'($urandom), l);
            sent++;
         end
      end
      wait_idle();
      req_idle_pct = 27;
      rsp_idle_pct = 27;
   endtask

   // ---------------------------------------------------------------------
   // response side: random stalls plus an occasional counted hold-off
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (rsp_hold_left > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // response checker: capture at the rising edge, compare at the falling edge
   initial begin
      crc_result_type exp_r;
      logic [31:0]    got_crc;
      logic           got_last;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_crc  = rsp_tdata;
            got_last = rsp_tlast;
            @(negedge clock);
            rsp_checked++;
            if (crc_expect_q.size() == 0) begin
               report_mismatch("response with no item pending", 32'h0, got_crc);
            end else begin
               exp_r = crc_expect_q.pop_front();
               if (got_crc !== exp_r.crc)
                  report_mismatch($sformatf("crc of response %0d", rsp_checked),
                                  exp_r.crc, got_crc);
               if (got_last !== exp_r.fin)
                  report_mismatch($sformatf("tlast of response %0d", rsp_checked),
                                  32'(exp_r.fin), 32'(got_last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, crc_expect_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      kind_model    = KIND_CRC32;
      crc_model     = 32'h0;
      req_idle_pct  = 27;
      rsp_idle_pct  = 27;
      rsp_hold_left = 0;
      cycle_count   = 0;
      mismatches    = 0;
      items_sent    = 0;
      items_crc32   = 0;
      items_crc32c  = 0;
      msgs_started  = 0;
      rsp_checked   = 0;
      kind_writes   = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_vectors();
      test_kind_switch();
      test_backpressure();

      // random phases, the fourth one with no idling on either side
      for (int p = 0; p < 6; p++) begin
         write_kind((p % 2 == 0) ? KIND_CRC32 : KIND_CRC32C);
         test_random_messages(260, (p == 3) ? 0 : 27);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      mismatches += crc_expect_q.size();

      $display("run covered %0d items in %0d messages (CRC-32 %0d, CRC-32C %0d), %0d checked",
               items_sent, msgs_started, items_crc32, items_crc32c, rsp_checked);
      $display("%0d polynomial writes, %0d cycles, %0d failures",
               kind_writes, cycle_count, mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
src/crc32re_pkg.sv
src/crc32re_front.sv
src/crc32re_queue.sv
src/crc32re_back.sv
src/crc32_reflected_engine_core.sv
src/crc32re_checker.sv
tb/tb_crc32_reflected_engine_core.sv
